// ===== rtl/core/mamp_pkg.sv =====
// ----------------------------------------------------------------------------
// mamp_pkg
// Shared widths and transaction types for the moving-average motion profiler.
// ----------------------------------------------------------------------------
`default_nettype none

package mamp_pkg;

  localparam int MAX_WINDOW = 1024;
  localparam int WIN_W      = 11;
  localparam int PTR_W      = $clog2(MAX_WINDOW);
  localparam int POS_W      = 32;
  localparam int STEP_W     = POS_W + 1;
  localparam int NUM_W      = STEP_W + 1;
  localparam int ACC_W      = 40;
  localparam int SUM_W      = ACC_W + 1;
  localparam int CNT_W      = $clog2(NUM_W + 1);

  localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(10);
  localparam logic [WIN_W-1:0] WIN_MAX   = WIN_W'(MAX_WINDOW);

  typedef struct packed {
    logic                    start_req;
    logic                    has_sample;
    logic signed [POS_W-1:0] target_position;
  } in_t;

  typedef struct packed {
    logic signed [POS_W-1:0] profiled_position;
    logic signed [ACC_W-1:0] filtered_step;
    logic                    saturated;
  } out_t;

  typedef struct packed {
    logic                    start;
    logic signed [NUM_W-1:0] numer;
    logic [WIN_W-1:0]        denom;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [NUM_W-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/mamp_div.sv =====
// ----------------------------------------------------------------------------
// mamp_div
// Serial signed divider, one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module mamp_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire mamp_pkg::div_req_t req,
  output mamp_pkg::div_rsp_t      rsp
);

  logic                              busy_r;
  logic                              neg_r;
  logic [mamp_pkg::CNT_W-1:0]        cnt_r;
  logic [mamp_pkg::NUM_W-1:0]        dvd_r;
  logic [mamp_pkg::WIN_W-1:0]        den_r;
  logic [mamp_pkg::WIN_W-1:0]        rem_r;
  logic                              done_r;
  logic signed [mamp_pkg::NUM_W-1:0] quot_r;

  logic [mamp_pkg::WIN_W:0]   rem_sh;
  logic                       ge;
  logic [mamp_pkg::WIN_W:0]   rem_sub;
  logic [mamp_pkg::NUM_W-1:0] mag;

  assign rem_sh  = {rem_r, dvd_r[mamp_pkg::NUM_W-1]};
  assign ge      = rem_sh >= {1'b0, den_r};
  assign rem_sub = rem_sh - {1'b0, den_r};
  assign mag     = req.numer[mamp_pkg::NUM_W-1] ? -req.numer : req.numer;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        neg_r  <= req.numer[mamp_pkg::NUM_W-1];
        dvd_r  <= mag;
        den_r  <= req.denom;
        rem_r  <= '0;
        cnt_r  <= mamp_pkg::CNT_W'(mamp_pkg::NUM_W);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          quot_r <= neg_r ? -$signed(dvd_r) : $signed(dvd_r);
        end else begin
          cnt_r <= cnt_r - 1'b1;
          rem_r <= ge ? rem_sub[mamp_pkg::WIN_W-1:0] : rem_sh[mamp_pkg::WIN_W-1:0];
          dvd_r <= {dvd_r[mamp_pkg::NUM_W-2:0], ge};
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

`default_nettype wire

// ===== rtl/core/moving_average_motion_profiler.sv =====
// ----------------------------------------------------------------------------
// moving_average_motion_profiler
// Moving-average smoothing of target positions into a Q16.16 position profile.
// ----------------------------------------------------------------------------
// channel   direction  handshake              payload
// in_       input      in_valid / in_ready    mamp_pkg::in_t
// out_      output     out_valid / out_ready  mamp_pkg::out_t
// cfg_      input      cfg_we                 window_length, 11 bits
//
// a normal transaction's length from acceptance back to ready is set by the
// serial divider (one quotient bit per cycle over a 34-bit numerator)
// a start transaction goes straight from idle to the done state
// the result sits in an output register; the next transaction is accepted
// while it waits, and a stalled output holds the block before its next result
// reset is synchronous; the step history needs no clearing
// ----------------------------------------------------------------------------
`default_nettype none

module moving_average_motion_profiler (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire mamp_pkg::in_t                in_data,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output mamp_pkg::out_t                    out_data,
  input  wire logic                         cfg_we,
  input  wire logic [mamp_pkg::WIN_W-1:0]   cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_DIV,
    S_WAIT,
    S_ACC,
    S_POS,
    S_DONE
  } state_t;

  state_t                             state_r;
  logic [mamp_pkg::WIN_W-1:0]         win_r;
  logic signed [mamp_pkg::POS_W-1:0]  prev_r;
  logic                               seen_r;
  logic [mamp_pkg::PTR_W-1:0]         ptr_r;
  logic [mamp_pkg::WIN_W-1:0]         tc_r;
  logic signed [mamp_pkg::ACC_W-1:0]  acc_r;
  logic signed [mamp_pkg::POS_W-1:0]  pos_r;
  logic signed [mamp_pkg::STEP_W-1:0] s_r;
  logic                               ramp_r;
  logic [mamp_pkg::WIN_W-1:0]         den_r;
  logic signed [mamp_pkg::NUM_W-1:0]  num_r;
  logic signed [mamp_pkg::NUM_W-1:0]  quot_r;
  logic signed [mamp_pkg::STEP_W-1:0] hist_rd_r;
  mamp_pkg::out_t                     res_r;
  logic                               out_valid_r;
  mamp_pkg::out_t                     out_data_r;

  logic signed [mamp_pkg::STEP_W-1:0] hist_mem [mamp_pkg::MAX_WINDOW];

  logic                               accept;
  logic [mamp_pkg::WIN_W-1:0]         w_eff;
  logic signed [mamp_pkg::STEP_W-1:0] s_new;
  logic [mamp_pkg::WIN_W-1:0]         tc_inc;
  logic                               ramp_new;
  logic [mamp_pkg::PTR_W-1:0]         old_idx;
  logic signed [mamp_pkg::SUM_W-1:0]  acc_sum;
  logic signed [mamp_pkg::ACC_W-1:0]  acc_sat;
  logic signed [mamp_pkg::SUM_W-1:0]  pos_sum;
  logic                               pos_ovf;
  logic signed [mamp_pkg::POS_W-1:0]  pos_sat;
  logic                               out_free;
  mamp_pkg::div_req_t                 div_req;
  mamp_pkg::div_rsp_t                 div_rsp;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    if (win_r == '0) begin
      w_eff = mamp_pkg::WIN_W'(1);
    end else if (win_r > mamp_pkg::WIN_MAX) begin
      w_eff = mamp_pkg::WIN_MAX;
    end else begin
      w_eff = win_r;
    end
  end

  assign s_new = (in_data.has_sample && seen_r)
               ? (mamp_pkg::STEP_W'(in_data.target_position) - mamp_pkg::STEP_W'(prev_r))
               : '0;
  assign tc_inc   = (tc_r <= w_eff) ? tc_r + 1'b1 : tc_r;
  assign ramp_new = (tc_inc <= w_eff);
  assign old_idx  = ptr_r - w_eff[mamp_pkg::PTR_W-1:0];

  // accumulator and position update with clipping
  assign acc_sum = mamp_pkg::SUM_W'(acc_r) + mamp_pkg::SUM_W'(quot_r);
  always_comb begin
    if (acc_sum[mamp_pkg::SUM_W-1] != acc_sum[mamp_pkg::SUM_W-2]) begin
      acc_sat = acc_sum[mamp_pkg::SUM_W-1]
              ? {1'b1, {(mamp_pkg::ACC_W-1){1'b0}}}
              : {1'b0, {(mamp_pkg::ACC_W-1){1'b1}}};
    end else begin
      acc_sat = acc_sum[mamp_pkg::ACC_W-1:0];
    end
  end

  assign pos_sum = mamp_pkg::SUM_W'(pos_r) + mamp_pkg::SUM_W'(acc_r);
  assign pos_ovf = !((&pos_sum[mamp_pkg::SUM_W-1:mamp_pkg::POS_W-1]) ||
                     !(|pos_sum[mamp_pkg::SUM_W-1:mamp_pkg::POS_W-1]));
  always_comb begin
    if (pos_ovf) begin
      pos_sat = pos_sum[mamp_pkg::SUM_W-1]
              ? {1'b1, {(mamp_pkg::POS_W-1){1'b0}}}
              : {1'b0, {(mamp_pkg::POS_W-1){1'b1}}};
    end else begin
      pos_sat = pos_sum[mamp_pkg::POS_W-1:0];
    end
  end

  // step history, read before write on the same entry
  always_ff @(posedge clk) begin
    if (accept && !in_data.start_req) begin
      hist_mem[ptr_r] <= s_new;
      hist_rd_r       <= hist_mem[old_idx];
    end
  end

  assign div_req.start = (state_r == S_DIV);
  assign div_req.numer = num_r;
  assign div_req.denom = den_r;

  mamp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      win_r       <= mamp_pkg::WIN_RESET;
      prev_r      <= '0;
      seen_r      <= 1'b0;
      ptr_r       <= '0;
      tc_r        <= '0;
      acc_r       <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        win_r <= cfg_wdata;
      end
      if (out_valid_r && out_ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (in_data.start_req) begin
              ptr_r                   <= '0;
              tc_r                    <= '0;
              acc_r                   <= '0;
              seen_r                  <= 1'b0;
              pos_r                   <= in_data.target_position;
              res_r.profiled_position <= in_data.target_position;
              res_r.filtered_step     <= '0;
              res_r.saturated         <= 1'b0;
              state_r                 <= S_DONE;
            end else begin
              if (in_data.has_sample) begin
                prev_r <= in_data.target_position;
                seen_r <= 1'b1;
              end
              s_r     <= s_new;
              tc_r    <= tc_inc;
              ramp_r  <= ramp_new;
              den_r   <= ramp_new ? tc_inc : w_eff;
              ptr_r   <= ptr_r + 1'b1;
              state_r <= S_LOAD;
            end
          end
        end
        S_LOAD: begin
          num_r   <= ramp_r ? mamp_pkg::NUM_W'(s_r)
                            : mamp_pkg::NUM_W'(s_r) - mamp_pkg::NUM_W'(hist_rd_r);
          state_r <= S_DIV;
        end
        S_DIV: begin
          state_r <= S_WAIT;
        end
        S_WAIT: begin
          if (div_rsp.done) begin
            quot_r  <= div_rsp.quot;
            state_r <= S_ACC;
          end
        end
        S_ACC: begin
          acc_r   <= acc_sat;
          state_r <= S_POS;
        end
        S_POS: begin
          pos_r                   <= pos_sat;
          res_r.profiled_position <= pos_sat;
          res_r.filtered_step     <= acc_r;
          res_r.saturated         <= pos_ovf;
          state_r                 <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_data_r  <= res_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== verif/tb_moving_average_motion_profiler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_moving_average_motion_profiler
// Self-checking bench for the moving-average motion profiler. A scoreboard
// class tracks the profile state (previous target, step history, tick count,
// running step, position) and predicts each result transaction. Directed
// ticks hit the position extremes, start and first-sample handling and both
// saturation limits. Random well-formed profiles with mixed step sizes,
// rest ticks and noise follow. The window is changed between phases,
// including out-of-range values, and the idle/stall pattern changes with it.
// ----------------------------------------------------------------------------
module tb_moving_average_motion_profiler;
  import mamp_pkg::*;

  localparam int     SETTLE_CYCLES = 50;
  localparam int     CYCLE_LIMIT   = 1_000_000;
  localparam int     PHASE_TICKS   = 85;
  localparam int     NUM_PHASES    = 8;
  localparam int     REPORT_LIMIT  = 10;
  localparam longint ACC_HI        = (longint'(1) <<< (ACC_W - 1)) - 1;
  localparam longint ACC_LO        = -(longint'(1) <<< (ACC_W - 1));
  localparam longint POS_HI        = (longint'(1) <<< (POS_W - 1)) - 1;
  localparam longint POS_LO        = -(longint'(1) <<< (POS_W - 1));
  localparam logic signed [POS_W-1:0] TARGET_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [POS_W-1:0] TARGET_MIN = 32'sh8000_0000;

  class profile_scoreboard;
    logic [WIN_W-1:0] window;
    longint           prev_target;
    bit               target_seen;
    longint           step_hist[MAX_WINDOW];
    longint           hist_ptr;
    longint           tick_cnt;
    longint           step_acc;
    longint           position;
    out_t             expected_profile[$];
    int               mismatches;

    function new();
      window      = WIN_RESET;
      prev_target = 0;
      target_seen = 0;
      hist_ptr    = 0;
      tick_cnt    = 0;
      step_acc    = 0;
      position    = 0;
      mismatches  = 0;
      foreach (step_hist[k]) step_hist[k] = 0;
    endfunction

    function void set_window(logic [WIN_W-1:0] value);
      window = value;
    endfunction

    function int pending();
      return expected_profile.size();
    endfunction

    function void note_tick(in_t t);
      out_t   want;
      longint target;
      longint step;
      longint delta;
      longint w;
      longint next_pos;
      bit     sat;
      target = longint'(t.target_position);
      sat    = 1'b0;
      if (t.start_req) begin
        foreach (step_hist[k]) step_hist[k] = 0;
        hist_ptr           = 0;
        tick_cnt           = 0;
        step_acc           = 0;
        target_seen        = 0;
        position           = target;
        want.filtered_step = '0;
      end else begin
        w = window;
        if (w == 0) w = 1;
        if (w > MAX_WINDOW) w = MAX_WINDOW;
        step = 0;
        if (t.has_sample) begin
          if (target_seen) step = target - prev_target;
          prev_target = target;
          target_seen = 1;
        end
        if (tick_cnt <= w) tick_cnt++;
        if (tick_cnt <= w) begin
          delta = step / tick_cnt;
        end else begin
          delta = (step - step_hist[(hist_ptr + MAX_WINDOW - w) % MAX_WINDOW]) / w;
        end
        step_hist[hist_ptr] = step;
        hist_ptr            = (hist_ptr + 1) % MAX_WINDOW;
        step_acc            = step_acc + delta;
        if (step_acc > ACC_HI) step_acc = ACC_HI;
        if (step_acc < ACC_LO) step_acc = ACC_LO;
        next_pos = position + step_acc;
        if (next_pos > POS_HI) begin
          next_pos = POS_HI;
          sat      = 1'b1;
        end
        if (next_pos < POS_LO) begin
          next_pos = POS_LO;
          sat      = 1'b1;
        end
        position           = next_pos;
        want.filtered_step = step_acc[ACC_W-1:0];
      end
      want.profiled_position = position[POS_W-1:0];
      want.saturated         = sat;
      expected_profile = {expected_profile, want};
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (expected_profile.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: result with nothing expected: pos %0d step %0d sat %0b",
                   $realtime, got.profiled_position, got.filtered_step, got.saturated);
        return;
      end
      want = expected_profile.pop_front();
      if (got.profiled_position !== want.profiled_position ||
          got.filtered_step !== want.filtered_step ||
          got.saturated !== want.saturated) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: mismatch: expected pos %0d step %0d sat %0b, got pos %0d step %0d sat %0b",
                   $realtime, want.profiled_position, want.filtered_step, want.saturated,
                   got.profiled_position, got.filtered_step, got.saturated);
      end
    endfunction
  endclass

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  in_t               in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_t              out_data;
  logic              cfg_we    = 1'b0;
  logic [WIN_W-1:0]  cfg_wdata = '0;

  int                idle_pct    = 0;
  int                stall_pct   = 0;
  int unsigned       cycle_count = 0;
  logic signed [POS_W-1:0] walk_pos = '0;
  profile_scoreboard profile;

  logic [WIN_W-1:0]  phase_window[NUM_PHASES] = '{11'd10, 11'd1, 11'd0, 11'd2047,
                                                  11'd3, 11'd1024, 11'd2, 11'd37};

  moving_average_motion_profiler DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) profile.check_result(out_data);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic in_t make_tick(bit start, bit has, logic signed [POS_W-1:0] target);
    in_t t;
    t.start_req       = start;
    t.has_sample      = has;
    t.target_position = target;
    return t;
  endfunction

  // mostly sample ticks along a random walk, some rest ticks, starts and noise
  function automatic in_t random_tick();
    in_t                     t;
    int                      pick;
    logic signed [POS_W-1:0] jump;
    pick              = $urandom_range(99);
    t.start_req       = 1'b0;
    t.has_sample      = 1'b1;
    t.target_position = $urandom;
    if (pick < 2) begin
      t.start_req  = 1'b1;
      t.has_sample = 1'($urandom_range(1));
      walk_pos     = t.target_position;
    end else if (pick < 12) begin
      t.start_req  = ($urandom_range(15) == 0);
      t.has_sample = 1'($urandom_range(1));
    end else if (pick < 25) begin
      t.has_sample = 1'b0;
    end else begin
      jump = $urandom;
      if ($urandom_range(3) == 0) begin
        walk_pos = $urandom_range(1) ? TARGET_MAX : TARGET_MIN;
      end else begin
        walk_pos = walk_pos + (jump >>> $urandom_range(31));
      end
      t.target_position = walk_pos;
    end
    return t;
  endfunction

  task automatic send_tick(in_t t);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (!in_ready);
    profile.note_tick(t);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (profile.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(logic [WIN_W-1:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    profile.set_window(value);
  endtask

  task automatic set_idle_mode(int mode);
    case (mode)
      0: begin
        idle_pct  = 0;
        stall_pct = 0;
      end
      1: begin
        idle_pct  = 79;
        stall_pct = 0;
      end
      2: begin
        idle_pct  = 0;
        stall_pct = 79;
      end
      default: begin
        idle_pct  = 10;
        stall_pct = 10;
      end
    endcase
  endtask

  task automatic run_directed();
    // rest tick from reset, then first sample and steps across full range
    send_tick(make_tick(1'b0, 1'b0, 32'sh0000_0000));
    send_tick(make_tick(1'b0, 1'b1, 32'sh1234_5678));
    send_tick(make_tick(1'b0, 1'b1, 32'sh1235_0000));
    send_tick(make_tick(1'b0, 1'b1, TARGET_MAX));
    send_tick(make_tick(1'b0, 1'b1, TARGET_MIN));
    send_tick(make_tick(1'b0, 1'b1, TARGET_MAX));
    repeat (2) send_tick(make_tick(1'b0, 1'b0, 32'sh5555_AAAA));
    // start ignores has_sample, then drive to the negative limit
    send_tick(make_tick(1'b1, 1'b1, TARGET_MAX));
    send_tick(make_tick(1'b0, 1'b1, TARGET_MAX));
    repeat (2) send_tick(make_tick(1'b0, 1'b1, TARGET_MIN));
    // start at the negative limit, then jump to the positive limit
    send_tick(make_tick(1'b1, 1'b0, TARGET_MIN));
    send_tick(make_tick(1'b0, 1'b1, TARGET_MIN));
    send_tick(make_tick(1'b0, 1'b1, TARGET_MAX));
    // rest ticks run past the window into the steady-state rule
    repeat (10) send_tick(make_tick(1'b0, 1'b0, 32'sh0000_0000));
  endtask

  initial begin
    profile = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) write_window(phase_window[ph]);
      set_idle_mode(ph % 4);
      repeat (PHASE_TICKS) send_tick(random_tick());
    end
    drain();
    if (profile.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
